@@ design/hybrid_bisection_secant_root_finder_unit_macros.svh @@
// Assertion macros for the hybrid root finder.
// Included by modules that carry concurrent checks.
`ifndef HYBRID_BISECTION_SECANT_ROOT_FINDER_UNIT_MACROS_SVH
`define HYBRID_BISECTION_SECANT_ROOT_FINDER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define HBS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HBS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HBS_ASSERT(lbl, clk, rstn, prop, msg)
`define HBS_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

@@ design/hbs_pkg.sv @@
// Shared types and codes for the hybrid root finder.
// No dependencies.
package hbs_pkg;
  localparam logic [1:0] ST_EVAL  = 2'd0;
  localparam logic [1:0] ST_ROOT  = 2'd1;
  localparam logic [1:0] ST_EXH   = 2'd2;
  localparam logic [1:0] ST_FAULT = 2'd3;

  localparam logic [1:0] REG_MAXEV = 2'd0;
  localparam logic [1:0] REG_VTOL  = 2'd1;
  localparam logic [1:0] REG_WTOL  = 2'd2;
  localparam logic [1:0] REG_SWW   = 2'd3;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

@@ design/hbs_muldiv.sv @@
// Shared multiply/divide: signed x*y/z, one quotient bit per cycle, saturated.
// Depends on hbs_pkg.
module hbs_muldiv #(
  parameter int VB = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [VB-1:0] x_i,
  input  logic signed [VB-1:0] y_i,
  input  logic signed [VB-1:0] z_i,
  output hbs_pkg::div_ctl_t    ctl_o,
  output logic signed [VB-1:0] q_o
);
  import hbs_pkg::*;
  localparam int PW = 2 * VB;
  localparam int CW = $clog2(PW + 1);

  logic [PW-1:0] prod_q, prod_d;
  logic [VB:0]   rem_q, rem_d;
  logic [PW-1:0] quo_q, quo_d;
  logic [VB-1:0] den_q, den_d;
  logic          neg_q, neg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [VB-1:0] ax, ay, az;
  logic [VB:0]   trial;
  logic [PW-1:0] lim;

  assign ax = x_i[VB-1] ? VB'(-x_i) : VB'(x_i);
  assign ay = y_i[VB-1] ? VB'(-y_i) : VB'(y_i);
  assign az = z_i[VB-1] ? VB'(-z_i) : VB'(z_i);
  assign trial = {rem_q[VB-1:0], prod_q[PW-1]};

  always_comb begin
    prod_d = prod_q; rem_d = rem_q; quo_d = quo_q; den_d = den_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      prod_d = PW'(ax) * PW'(ay);
      den_d  = az;
      neg_d  = (x_i[VB-1] ^ y_i[VB-1]) ^ z_i[VB-1];
      rem_d  = '0; quo_d = '0;
      cnt_d  = CW'(PW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      prod_d = {prod_q[PW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[PW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[PW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d; rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

  always_comb begin
    lim = neg_q ? (PW'(1) << (VB - 1)) : ((PW'(1) << (VB - 1)) - PW'(1));
    if (quo_q > lim) q_o = neg_q ? VB'(-lim) : VB'(lim);
    else             q_o = neg_q ? VB'(-quo_q) : VB'(quo_q);
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign ctl_o.done  = done_q;
endmodule

@@ design/hybrid_bisection_secant_root_finder_unit.sv @@
// Hybrid bisection/secant root finder: each word in gives at most one word out.
// Start words and the left end value answer in the cycle after accept. Bisection steps go
// through S_ADV; secant steps through S_ADV, S_DEN, S_DIV, S_SUB (shared divider), S_OUT.
// One word in flight at a time; a finished word sits in an output register.
// rst_ni is asynchronous, active low: idle, all but den/dx/output word at reset values.
`include "hybrid_bisection_secant_root_finder_unit_macros.svh"
module hybrid_bisection_secant_root_finder_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // left_end, right_end, function_value
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // status, point, zero pad
);
  import hbs_pkg::*;
  localparam int VB = VALUE_BITS;
  localparam logic [2:0] PH_IDLE = 3'd0, PH_WL = 3'd1, PH_WR = 3'd2, PH_BS = 3'd3,
                         PH_SS = 3'd4, PH_SR = 3'd5, PH_BO = 3'd6, PH_SO = 3'd7;
  localparam logic [2:0] S_IDLE = 3'd0, S_ADV = 3'd1, S_DEN = 3'd2, S_DIV = 3'd3,
                         S_SUB = 3'd4, S_OUT = 3'd5;
  localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

  logic [15:0] maxev_q;
  logic [30:0] vtol_q, wtol_q, sww_q;
  logic signed [VB-1:0] lp_q, lp_d, rp_q, rp_d, lf_q, lf_d, rf_q, rf_d;
  logic signed [VB-1:0] hw_q, hw_d, pp_q, pp_d, den_q, den_d, dx_q, dx_d;
  logic [15:0] ec_q, ec_d;
  logic [2:0]  ph_q, ph_d, st_q, st_d;
  logic        ov_q, ov_d;
  logic [1:0]  ost_q, ost_d;
  logic signed [VB-1:0] opt_q, opt_d;
  logic        div_start;
  div_ctl_t    dctl;
  logic signed [VB-1:0] quo;

  function automatic logic signed [VB-1:0] ssub(logic signed [VB-1:0] a,
                                                logic signed [VB-1:0] b);
    logic signed [VB:0] s;
    s = {a[VB-1], a} - {b[VB-1], b};
    if (s[VB] != s[VB-1]) return s[VB] ? VMIN : VMAX;
    return s[VB-1:0];
  endfunction
  function automatic logic signed [VB-1:0] sadd(logic signed [VB-1:0] a,
                                                logic signed [VB-1:0] b);
    logic signed [VB:0] s;
    s = {a[VB-1], a} + {b[VB-1], b};
    if (s[VB] != s[VB-1]) return s[VB] ? VMIN : VMAX;
    return s[VB-1:0];
  endfunction
  function automatic logic [VB:0] magv(logic signed [VB-1:0] a);
    logic signed [VB:0] e;
    e = {a[VB-1], a};
    return a[VB-1] ? (VB+1)'(-e) : (VB+1)'(e);
  endfunction
  function automatic logic signed [VB-1:0] fin(logic [31:0] x);
    logic signed [63:0] e;
    e = 64'(signed'(x));
    if (e > 64'(VMAX)) return VMAX;
    if (e < 64'(VMIN)) return VMIN;
    return VB'(e);
  endfunction
  function automatic logic [31:0] fout(logic signed [VB-1:0] p);
    logic signed [63:0] e;
    e = 64'(p);
    if (e > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (e < -64'sh8000_0000) return 32'h8000_0000;
    return e[31:0];
  endfunction

  hbs_muldiv #(.VB(VB)) u_md (
    .clk_i, .rst_ni, .start_i(div_start), .x_i(rf_q), .y_i(dx_q), .z_i(den_q),
    .ctl_o(dctl), .q_o(quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxev_q <= 16'd64; vtol_q <= 31'd7; wtol_q <= 31'd7; sww_q <= 31'd6554;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAXEV: maxev_q <= cfg_wdata_i[15:0];
        REG_VTOL:  vtol_q  <= cfg_wdata_i;
        REG_WTOL:  wtol_q  <= cfg_wdata_i;
        REG_SWW:   sww_q   <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  logic                 acc;
  logic                 opc;
  logic signed [VB-1:0] v_in;
  logic                 budget;
  // signed compare of half width against the switch width
  logic signed [64:0]   hwe, swe;
  assign s_axis_tready = (st_q == S_IDLE) && !ov_q;
  assign acc  = s_axis_tvalid && s_axis_tready;
  assign opc  = s_axis_tuser;
  assign v_in = fin(s_axis_tdata[95:64]);
  assign budget = ec_q < maxev_q;
  assign hwe = 65'(hw_q);
  assign swe = 65'(sww_q);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = {6'd0, fout(opt_q), ost_q};

  always_comb begin
    logic signed [VB-1:0] lp2, rp2, lf2, rf2;
    logic                 stop;
    lp_d = lp_q; rp_d = rp_q; lf_d = lf_q; rf_d = rf_q; hw_d = hw_q; pp_d = pp_q;
    den_d = den_q; dx_d = dx_q; ec_d = ec_q; ph_d = ph_q; st_d = st_q;
    ov_d = ov_q; ost_d = ost_q; opt_d = opt_q; div_start = 1'b0;
    lp2 = lp_q; rp2 = rp_q; lf2 = lf_q; rf2 = rf_q; stop = 1'b0;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (acc) begin
          if (!opc) begin
            lp_d = fin(s_axis_tdata[31:0]); rp_d = fin(s_axis_tdata[63:32]);
            ec_d = '0; ph_d = PH_WL; ost_d = ST_EVAL; opt_d = fin(s_axis_tdata[31:0]);
            ov_d = 1'b1;
          end else begin
            unique case (ph_q)
              PH_IDLE: ;
              PH_WL: begin
                lf_d = v_in; ph_d = PH_WR; ost_d = ST_EVAL; opt_d = rp_q; ov_d = 1'b1;
              end
              PH_WR: begin
                rf_d = v_in; ec_d = 16'd2;
                if (magv(lf_q) < (VB+1)'(vtol_q)) begin
                  ph_d = PH_IDLE; ost_d = ST_ROOT; opt_d = lp_q; ov_d = 1'b1;
                end else if (magv(v_in) < (VB+1)'(vtol_q)) begin
                  ph_d = PH_IDLE; ost_d = ST_ROOT; opt_d = rp_q; ov_d = 1'b1;
                end else if (lf_q != 0 && v_in != 0 && lf_q[VB-1] != v_in[VB-1]) begin
                  hw_d = ssub(rp_q, lp_q); ph_d = PH_BS; st_d = S_ADV;
                end else begin
                  ph_d = PH_SR; st_d = S_ADV;
                end
              end
              default: begin
                if (magv(v_in) < (VB+1)'(vtol_q) ||
                    magv(ssub(rp_q, lp_q)) < (VB+1)'(wtol_q)) begin
                  stop = 1'b1;
                  ph_d = PH_IDLE; ost_d = ST_ROOT; opt_d = pp_q; ov_d = 1'b1;
                end else if (ph_q == PH_BS || ph_q == PH_BO) begin
                  if (v_in[VB-1] != lf_q[VB-1]) begin rp2 = pp_q; rf2 = v_in; end
                  else begin lp2 = pp_q; lf2 = v_in; end
                end else begin
                  lp2 = rp_q; lf2 = rf_q; rp2 = pp_q; rf2 = v_in;
                end
                if (!stop) begin
                  lp_d = lp2; rp_d = rp2; lf_d = lf2; rf_d = rf2;
                  if (magv(lf2) < (VB+1)'(vtol_q)) begin
                    ph_d = PH_IDLE; ost_d = ST_ROOT; opt_d = lp2; ov_d = 1'b1;
                  end else if (magv(rf2) < (VB+1)'(vtol_q)) begin
                    ph_d = PH_IDLE; ost_d = ST_ROOT; opt_d = rp2; ov_d = 1'b1;
                  end else begin
                    if (ec_q != 16'hFFFF) ec_d = ec_q + 16'd1;
                    st_d = S_ADV;
                  end
                end
              end
            endcase
          end
        end
      end
      S_ADV: begin
        unique case (ph_q)
          PH_BS, PH_BO: begin
            if (budget && (ph_q == PH_BS ? hwe > swe : hwe >= swe)) begin
              hw_d = hw_q / 2;
              pp_d = sadd(lp_q, hw_q / 2);
              ost_d = ST_EVAL; opt_d = sadd(lp_q, hw_q / 2); ov_d = 1'b1; st_d = S_IDLE;
            end else begin
              ph_d = (ph_q == PH_BS) ? PH_SS : PH_SO;
            end
          end
          PH_SS, PH_SO: begin
            if (budget) st_d = S_DEN;
            else begin
              ph_d = PH_IDLE; ost_d = ST_EXH; opt_d = '0; ov_d = 1'b1; st_d = S_IDLE;
            end
          end
          PH_SR: begin
            if (budget && lf_q != 0 && rf_q != 0 && lf_q[VB-1] == rf_q[VB-1]) begin
              st_d = S_DEN;
            end else begin
              if (rp_q < lp_q) begin
                lp_d = rp_q; rp_d = lp_q; lf_d = rf_q; rf_d = lf_q;
              end
              hw_d = (rp_q < lp_q) ? ssub(lp_q, rp_q) : ssub(rp_q, lp_q);
              ph_d = PH_BO;
            end
          end
          default: begin
            ph_d = PH_IDLE; st_d = S_IDLE;
          end
        endcase
      end
      S_DEN: begin
        den_d = ssub(rf_q, lf_q); dx_d = ssub(rp_q, lp_q);
        if (ssub(rf_q, lf_q) == 0) begin
          ph_d = PH_IDLE; ost_d = ST_FAULT; opt_d = '0; ov_d = 1'b1; st_d = S_IDLE;
        end else st_d = S_DIV;
      end
      S_DIV: begin
        div_start = 1'b1; st_d = S_SUB;
      end
      S_SUB: begin
        if (dctl.done) begin
          pp_d = ssub(rp_q, quo); ost_d = ST_EVAL; opt_d = ssub(rp_q, quo);
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        ov_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q <= '0; rp_q <= '0; lf_q <= '0; rf_q <= '0; hw_q <= '0; pp_q <= '0;
      ec_q <= '0; ph_q <= PH_IDLE; st_q <= S_IDLE; ov_q <= 1'b0;
    end else begin
      lp_q <= lp_d; rp_q <= rp_d; lf_q <= lf_d; rf_q <= rf_d; hw_q <= hw_d; pp_q <= pp_d;
      ec_q <= ec_d; ph_q <= ph_d; st_q <= st_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d; dx_q <= dx_d; ost_q <= ost_d; opt_q <= opt_d;
  end

  `HBS_ASSERT(a_no_accept_busy, clk_i, rst_ni, (st_q != S_IDLE) |-> !s_axis_tready,
              "input taken while working")
  `HBS_ASSERT(a_div_only_sub, clk_i, rst_ni, dctl.busy |-> (st_q == S_SUB),
              "divider running outside secant step")
  `HBS_ASSERT(a_out_hold, clk_i, rst_ni,
              (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata),
              "output word changed while stalled")
endmodule

@@ tb/tb_hybrid_bisection_secant_root_finder_unit.sv @@
// Self-checking testbench for the hybrid bisection/secant root finder.
// Depends on hbs_pkg and hybrid_bisection_secant_root_finder_unit; a scoreboard
// class predicts each output word and plain tasks answer evaluation requests.
module tb_hybrid_bisection_secant_root_finder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import hbs_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_WAIT_LEFT, PH_WAIT_RIGHT, PH_BIS_SIGN,
    PH_SEC_SIGN, PH_SEC_SEARCH, PH_BIS_ORD, PH_SEC_ORD
  } search_phase_e;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  function automatic longint clamp32(longint x);
    if (x > VMAX) return VMAX;
    if (x < VMIN) return VMIN;
    return x;
  endfunction

  function automatic longint abs64(longint x);
    return (x < 0) ? -x : x;
  endfunction

  class root_scoreboard;
    longint lp, rp, lf, rf, hw, pp;
    int unsigned evals;
    search_phase_e ph;
    longint max_ev, vtol, wtol, sww;
    logic [1:0] status_q[$];
    logic [31:0] point_q[$];
    logic [1:0] last_st;
    longint last_pt;
    int errors;

    function void clear();
      max_ev = 64; vtol = 7; wtol = 7; sww = 6554;
      lp = 0; rp = 0; lf = 0; rf = 0; hw = 0; pp = 0;
      evals = 0; ph = PH_IDLE; errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, longint val);
      case (idx)
        REG_MAXEV: max_ev = val & 64'hFFFF;
        REG_VTOL:  vtol = val & 64'h7FFFFFFF;
        REG_WTOL:  wtol = val & 64'h7FFFFFFF;
        default:   sww = val & 64'h7FFFFFFF;
      endcase
    endfunction

    function bit tiny(longint v);
      return abs64(v) < vtol;
    endfunction

    function void put(logic [1:0] st, longint p, bit done);
      if (done) ph = PH_IDLE;
      last_st = st;
      last_pt = clamp32(p);
      status_q.push_back(st);
      point_q.push_back(last_pt[31:0]);
    endfunction

    function void secant_step();
      longint den, q;
      den = clamp32(rf - lf);
      if (den == 0) begin
        put(ST_FAULT, 0, 1);
        return;
      end
      q = clamp32((rf * clamp32(rp - lp)) / den);
      pp = clamp32(rp - q);
      put(ST_EVAL, pp, 0);
    endfunction

    function void advance();
      bit budget;
      longint t;
      forever begin
        budget = evals < max_ev;
        case (ph)
          PH_BIS_SIGN, PH_BIS_ORD: begin
            if (budget && ((ph == PH_BIS_SIGN) ? (hw > sww) : (hw >= sww))) begin
              hw = hw / 2;
              pp = clamp32(lp + hw);
              put(ST_EVAL, pp, 0);
              return;
            end
            ph = (ph == PH_BIS_SIGN) ? PH_SEC_SIGN : PH_SEC_ORD;
          end
          PH_SEC_SIGN, PH_SEC_ORD: begin
            if (budget) secant_step();
            else put(ST_EXH, 0, 1);
            return;
          end
          PH_SEC_SEARCH: begin
            if (budget && lf != 0 && rf != 0 && ((lf < 0) == (rf < 0))) begin
              secant_step();
              return;
            end
            if (rp < lp) begin
              t = rp; rp = lp; lp = t;
              t = rf; rf = lf; lf = t;
            end
            hw = clamp32(rp - lp);
            ph = PH_BIS_ORD;
          end
          default: begin
            ph = PH_IDLE;
            return;
          end
        endcase
      end
    endfunction

    // Model one accepted input word; at most one output word is queued.
    function void note_word(bit op, logic [31:0] l, logic [31:0] r, logic [31:0] f);
      longint v;
      v = longint'($signed(f));
      if (!op) begin
        lp = longint'($signed(l));
        rp = longint'($signed(r));
        evals = 0;
        ph = PH_WAIT_LEFT;
        put(ST_EVAL, lp, 0);
        return;
      end
      case (ph)
        PH_IDLE: return;
        PH_WAIT_LEFT: begin
          lf = v;
          ph = PH_WAIT_RIGHT;
          put(ST_EVAL, rp, 0);
          return;
        end
        PH_WAIT_RIGHT: begin
          rf = v;
          evals = 2;
          if (tiny(lf)) begin put(ST_ROOT, lp, 1); return; end
          if (tiny(rf)) begin put(ST_ROOT, rp, 1); return; end
          if (lf != 0 && rf != 0 && ((lf < 0) != (rf < 0))) begin
            hw = clamp32(rp - lp);
            ph = PH_BIS_SIGN;
          end else begin
            ph = PH_SEC_SEARCH;
          end
          advance();
          return;
        end
        default: ;
      endcase
      if (tiny(v) || abs64(clamp32(rp - lp)) < wtol) begin
        put(ST_ROOT, pp, 1);
        return;
      end
      if (ph == PH_BIS_SIGN || ph == PH_BIS_ORD) begin
        if ((v < 0) != (lf < 0)) begin rp = pp; rf = v; end
        else begin lp = pp; lf = v; end
      end else begin
        lp = rp; lf = rf;
        rp = pp; rf = v;
      end
      if (tiny(lf)) begin put(ST_ROOT, lp, 1); return; end
      if (tiny(rf)) begin put(ST_ROOT, rp, 1); return; end
      if (evals < 16'hFFFF) evals++;
      advance();
    endfunction

    function void check_word(logic [1:0] st, logic [31:0] pt);
      logic [1:0] exp_st;
      logic [31:0] exp_pt;
      if (status_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: status %0d point %h", st, pt);
        return;
      end
      exp_st = status_q.pop_front();
      exp_pt = point_q.pop_front();
      if (st !== exp_st || pt !== exp_pt) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: status exp %0d got %0d, point exp %h got %h",
                   exp_st, st, exp_pt, pt);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [30:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // left_end, right_end, function_value
  logic        s_axis_tuser = 1'b0; // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // status, point, zero pad

  root_scoreboard sb = new();
  int  words_sent = 0;
  bit  calm = 1'b0;   // no gaps on either side while set

  hybrid_bisection_secant_root_finder_unit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #10ms;
    $display("tb_hybrid_bisection_secant_root_finder_unit failed");
    $finish;
  end

  // Output side: random stall per word, tready held high across back-to-back words.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_word(m_axis_tdata[1:0], m_axis_tdata[33:2]);
    end
  end

  task automatic send_word(bit op, logic [31:0] l, logic [31:0] r, logic [31:0] f);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {f, r, l};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(op, l, r, f);
    words_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.status_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_regs(longint mev, longint vt, longint wt, longint sw);
    longint vals[4];
    vals = '{mev, vt, wt, sw};
    foreach (vals[i]) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= i[1:0];
      cfg_wdata_i <= vals[i][30:0];
      @(posedge clk_i);
      sb.write_reg(i[1:0], vals[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Function under search: 0 linear, 1 parabola, 2 constant, 3 noise.
  function automatic logic [31:0] f_at(longint x, int shape, longint root, longint k);
    longint d;
    case (shape)
      0: d = ((x - root) * k) >>> 16;
      1: d = (((x - root) >>> 8) * ((x - root) >>> 8)) - k;
      2: d = k;
      default: d = longint'($signed($urandom()));
    endcase
    d = clamp32(d);
    return d[31:0];
  endfunction

  task automatic run_search(longint l, longint r, int shape, longint root, longint k,
                            int cap);
    int n;
    n = 0;
    send_word(1'b0, l[31:0], r[31:0], $urandom());
    while (sb.ph != PH_IDLE && sb.last_st == ST_EVAL && n < cap) begin
      send_word(1'b1, $urandom(), $urandom(), f_at(sb.last_pt, shape, root, k));
      n++;
    end
  endtask

  initial begin
    int shape;
    longint root, span;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: value while idle, full-range interval, restart mid-search,
    // constant function (zero denominator), parabola without sign change
    calm = 1'b1;
    send_word(1'b1, 32'hFFFFFFFF, 32'h0, 32'h7FFFFFFF);
    send_word(1'b0, 32'h80000000, 32'h7FFFFFFF, 32'h0);
    send_word(1'b1, 32'h0, 32'h0, 32'h80000000);
    send_word(1'b1, 32'h0, 32'h0, 32'h7FFFFFFF);
    send_word(1'b1, 32'h0, 32'h0, 32'h10000);
    run_search(-64'sd2147483648, 64'sd2147483647, 0, 64'sd12345, 64'sd65536, 12);
    run_search(64'sd0, 64'sd65536, 2, 0, 64'sd5000, 8);
    run_search(-64'sd300000, 64'sd200000, 1, 64'sd70000, -64'sd1000000, 30);
    calm = 1'b0;
    drain();

    set_regs(2, 0, 0, 0);
    run_search(-64'sd65536, 64'sd65536, 0, 64'sd1000, 64'sd65536, 10);
    run_search(64'sd0, 64'sd65536, 2, 0, 64'sd0, 10);
    run_search(64'sd100, 64'sd900000, 1, 64'sd0, 64'sd0, 10);
    drain();

    set_regs(65535, 64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF);
    run_search(-64'sd65536, 64'sd65536, 0, 64'sd1000, 64'sd65536, 10);
    run_search(-64'sd65536, 64'sd65536, 3, 0, 0, 10);
    drain();

    set_regs(65535, 7, 0, 64'h7FFFFFFF);
    run_search(-64'sd65536, 64'sd131072, 0, 64'sd3000, -64'sd90000, 40);
    run_search(-64'sd65536, 64'sd131072, 3, 0, 0, 40);
    drain();

    while (words_sent < 620) begin
      set_regs($urandom_range(2, 200), $urandom_range(0, 100), $urandom_range(0, 100),
               $urandom_range(0, 1 << 20));
      calm = ($urandom_range(0, 3) == 0);
      repeat (12) begin
        shape = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 1) : $urandom_range(2, 3);
        root  = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        if ($urandom_range(0, 9) == 0) begin
          run_search(longint'($signed($urandom())), longint'($signed($urandom())), shape,
                     root, $signed($urandom_range(0, 1 << 21)) - (1 << 20), 40);
        end else begin
          span = $urandom_range(1, 1 << 20);
          run_search(root - $urandom_range(0, span), root + $urandom_range(0, span), shape,
                     root + $signed($urandom_range(0, 8192)) - 4096,
                     $signed($urandom_range(0, 1 << 21)) - (1 << 20),
                     $urandom_range(0, 9) == 0 ? $urandom_range(0, 4) : 40);
        end
        if ($urandom_range(0, 5) == 0 && sb.ph == PH_IDLE)
          send_word(1'b1, $urandom(), $urandom(), $urandom());
      end
      drain();
    end

    if (sb.errors == 0 && sb.status_q.size() == 0) begin
      $display("tb_hybrid_bisection_secant_root_finder_unit passed");
    end else begin
      $display("tb_hybrid_bisection_secant_root_finder_unit failed");
    end
    $finish;
  end

  initial sb.clear();
endmodule
